### design/uwc_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 display width counter: shared package
// Byte codes, the input item layout, lead byte decode and output saturation.
// ----------------------------------------------------------------------------
package uwc_pkg;

  // Width of the running accumulator (8 to 32).
  localparam int unsigned WIDTH_BITS = 16;
  // Width of the column_width result field.
  localparam int unsigned COL_W      = 16;
  localparam int unsigned EXT_W      = (WIDTH_BITS > COL_W) ? WIDTH_BITS : COL_W;

  localparam logic [7:0] ESC_BYTE     = 8'h1B;
  localparam logic [7:0] ASCII_LIMIT  = 8'h80;
  localparam logic [7:0] LEAD2_MASK   = 8'hE0;
  localparam logic [7:0] LEAD2_CODE   = 8'hC0;
  localparam logic [7:0] LEAD3_MASK   = 8'hF0;
  localparam logic [7:0] LEAD3_CODE   = 8'hE0;
  localparam logic [7:0] LEAD4_MASK   = 8'hF8;
  localparam logic [7:0] LEAD4_CODE   = 8'hF0;
  localparam logic [7:0] CSI_OPEN     = 8'h5B;  // '['
  localparam logic [7:0] CSI_FINAL_LO = 8'h40;  // '@'
  localparam logic [7:0] CSI_FINAL_HI = 8'h7E;  // '~'

  typedef struct packed {
    logic [7:0] text_byte;
    logic       is_final_byte;
  } item_t;

  // What a byte does when it is seen in normal text mode.
  typedef struct packed {
    logic       is_esc;
    logic [1:0] add;
    logic [1:0] skip;
  } lead_t;

  function automatic lead_t lead_decode(input logic [7:0] b);
    lead_t d;
    d = '0;
    if (b == ESC_BYTE) begin
      d.is_esc = 1'b1;
    end else if (b < ASCII_LIMIT) begin
      d.add = 2'd1;
    end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
      d.add  = 2'd1;
      d.skip = 2'd1;
    end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
      d.add  = 2'd2;
      d.skip = 2'd2;
    end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
      d.add  = 2'd2;
      d.skip = 2'd3;
    end
    return d;
  endfunction

  // Clamp the accumulator into the result field.
  function automatic logic [COL_W-1:0] sat_col(input logic [WIDTH_BITS-1:0] acc);
    logic [EXT_W-1:0] ext;
    logic [EXT_W-1:0] lim;
    ext = EXT_W'(acc);
    lim = EXT_W'({COL_W{1'b1}});
    return (ext > lim) ? {COL_W{1'b1}} : COL_W'(ext);
  endfunction

endpackage

### design/uwc_scan.sv
// ----------------------------------------------------------------------------
// UTF-8 display width counter: scanner
// Holds the scan mode, skip count and running width, and works out the
// next state and the result for the item in the input register.
// ----------------------------------------------------------------------------
module uwc_scan (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  uwc_pkg::item_t              item,
  output logic [uwc_pkg::COL_W-1:0]   result_width
);
  import uwc_pkg::*;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_ESC,
    MODE_CSI,
    MODE_SKIP
  } scan_mode_t;

  scan_mode_t            scan_mode;
  scan_mode_t            scan_mode_next;
  logic [1:0]            bytes_to_skip;
  logic [1:0]            bytes_to_skip_next;
  logic [WIDTH_BITS-1:0] width_accumulator;
  logic [WIDTH_BITS-1:0] width_next;
  logic [WIDTH_BITS:0]   width_sum;
  logic [1:0]            delta;
  logic [2:0]            delta_total;
  lead_t                 lead;

  assign lead = lead_decode(item.text_byte);

  always_comb begin
    scan_mode_next     = scan_mode;
    bytes_to_skip_next = bytes_to_skip;
    delta              = 2'd0;
    delta_total        = 3'd0;
    case (scan_mode)
      MODE_NORMAL, MODE_ESC: begin
        if (scan_mode == MODE_ESC && item.text_byte == CSI_OPEN) begin
          scan_mode_next = MODE_CSI;
        end else begin
          // A pending ESC not followed by '[' counts as a plain character.
          delta_total    = (scan_mode == MODE_ESC) ? 3'd1 : 3'd0;
          scan_mode_next = MODE_NORMAL;
          delta          = lead.add;
          if (lead.is_esc) begin
            scan_mode_next = MODE_ESC;
          end else if (lead.skip != 2'd0) begin
            scan_mode_next     = MODE_SKIP;
            bytes_to_skip_next = lead.skip;
          end
        end
      end
      MODE_CSI: begin
        if (item.text_byte >= CSI_FINAL_LO && item.text_byte <= CSI_FINAL_HI) begin
          scan_mode_next = MODE_NORMAL;
        end
      end
      default: begin
        if (bytes_to_skip <= 2'd1) begin
          bytes_to_skip_next = 2'd0;
          scan_mode_next     = MODE_NORMAL;
        end else begin
          bytes_to_skip_next = bytes_to_skip - 2'd1;
        end
      end
    endcase
    delta_total = delta_total + 3'(delta);
    // An ESC still pending at the end of the string counts one column.
    if (item.is_final_byte && scan_mode_next == MODE_ESC) begin
      delta_total = delta_total + 3'd1;
    end
  end

  assign width_sum  = {1'b0, width_accumulator} + (WIDTH_BITS + 1)'(delta_total);
  assign width_next = width_sum[WIDTH_BITS] ? {WIDTH_BITS{1'b1}} : width_sum[WIDTH_BITS-1:0];
  assign result_width = sat_col(width_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode         <= MODE_NORMAL;
      bytes_to_skip     <= 2'd0;
      width_accumulator <= '0;
    end else if (step) begin
      if (item.is_final_byte) begin
        scan_mode         <= MODE_NORMAL;
        bytes_to_skip     <= 2'd0;
        width_accumulator <= '0;
      end else begin
        scan_mode         <= scan_mode_next;
        bytes_to_skip     <= bytes_to_skip_next;
        width_accumulator <= width_next;
      end
    end
  end

endmodule

### design/uwc_out_stage.sv
// ----------------------------------------------------------------------------
// UTF-8 display width counter: result register
// Holds one finished width until the downstream side takes it.
// ----------------------------------------------------------------------------
module uwc_out_stage (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic [uwc_pkg::COL_W-1:0]   load_width,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [uwc_pkg::COL_W-1:0]   column_width,
  output logic                        hold
);
  import uwc_pkg::*;

  // Full and not being taken this cycle: a new result cannot enter.
  assign hold = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      column_width <= load_width;
    end
  end

endmodule

### design/utf8_display_width_counter.sv
// ----------------------------------------------------------------------------
// UTF-8 display width counter
// Counts the terminal columns of a byte string and gives the width when the
// last byte of the string has been processed.
//
//   Channel   Handshake             Payload
//   input     in_valid / in_ready   text_byte[7:0], is_final_byte
//   output    out_valid / out_ready column_width[15:0]
//
// One byte is accepted every cycle while the output side keeps up. A byte
// is registered in the input register, where the scanner updates its
// state as the byte moves on; a final byte's width is then loaded into the
// result register, from which it is shown.
// A final byte waits in the input register only while the result register
// still holds an untaken width. Reset clears all handshake and scan state.
// ----------------------------------------------------------------------------
module utf8_display_width_counter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  text_byte,
  input  logic                        is_final_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [uwc_pkg::COL_W-1:0]   column_width
);
  import uwc_pkg::*;

  logic              s1_valid;
  item_t             s1_item;
  logic              adv;
  logic              hold;
  logic [COL_W-1:0]  result_width;

  // Non-final items give no result, so only a final item can stall.
  assign adv      = s1_valid && (!s1_item.is_final_byte || !hold);
  assign in_ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.text_byte     <= text_byte;
      s1_item.is_final_byte <= is_final_byte;
    end
  end

  uwc_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .step         (adv),
    .item         (s1_item),
    .result_width (result_width)
  );

  uwc_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (adv && s1_item.is_final_byte),
    .load_width   (result_width),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .column_width (column_width),
    .hold         (hold)
  );

endmodule

### design/uwc_checker.sv
// ----------------------------------------------------------------------------
// UTF-8 display width counter: port checker
// Watches the top level's ports for ordering and stall behaviour.
// ----------------------------------------------------------------------------
module uwc_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        is_final_byte,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [uwc_pkg::COL_W-1:0]   column_width
);
  import uwc_pkg::*;

  // No result is shown in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown straight after reset");

  // The input side only stalls when a result is waiting downstream.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with an empty result register");

  // A fresh result always traces back to an accepted final item.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && is_final_byte, 2))
    else $error("result appeared without a final item");

  // A waiting result is held unchanged.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(column_width))
    else $error("waiting result dropped or changed");

endmodule

bind utf8_display_width_counter uwc_checker u_uwc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .is_final_byte (is_final_byte),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .column_width  (column_width)
);

### dv/utf8_display_width_counter_tb.sv
// ----------------------------------------------------------------------------
// UTF-8 display width counter: testbench
// Feeds byte strings through the valid/ready input and checks each width
// result against an in-bench scanner. A directed set covers the extremes,
// escape and CSI handling, multi-byte leads and cut-off sequences.
// Random strings follow under several idling patterns and one
// long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module utf8_display_width_counter_tb;
  import uwc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned PHASE_BYTES = 250;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef enum logic [1:0] {
    SCAN_TEXT,
    SCAN_ESC,
    SCAN_CSI,
    SCAN_SKIP
  } scan_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         text_byte = 8'h00;
  logic               is_final_byte = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [COL_W-1:0]   column_width;

  utf8_display_width_counter dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .text_byte     (text_byte),
    .is_final_byte (is_final_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .column_width  (column_width)
  );

  // Scanner state mirrored from the block.
  scan_t                 scan_mode = SCAN_TEXT;
  logic [1:0]            skip_left = 2'd0;
  logic [WIDTH_BITS-1:0] col_acc = '0;

  item_t            byte_q[$];
  logic [7:0]       str[$];
  logic [COL_W-1:0] width_q[$];
  item_t            next_item;
  logic [COL_W-1:0] want_width;

  int unsigned n_pushed = 0;
  int unsigned n_accepted = 0;
  int unsigned n_errors = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;
  logic        hold_go = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [COL_W-1:0] got,
                                 input logic [COL_W-1:0] want);
    $display("MISMATCH %s: got %0d, want %0d (cycle %0d)", what, got, want, cycle_cnt);
    n_errors++;
  endtask

  function automatic void add_cols(input int unsigned n);
    logic [WIDTH_BITS:0] sum;
    sum = {1'b0, col_acc} + (WIDTH_BITS + 1)'(n);
    col_acc = sum[WIDTH_BITS] ? {WIDTH_BITS{1'b1}} : sum[WIDTH_BITS-1:0];
  endfunction

  // A byte met in plain text: ESC goes pending, leads open a skip run.
  function automatic void take_text_byte(input logic [7:0] b);
    if (b == ESC_BYTE) begin
      scan_mode = SCAN_ESC;
    end else if (b < ASCII_LIMIT) begin
      add_cols(1);
    end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
      add_cols(1);
      scan_mode = SCAN_SKIP;
      skip_left = 2'd1;
    end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
      add_cols(2);
      scan_mode = SCAN_SKIP;
      skip_left = 2'd2;
    end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
      add_cols(2);
      scan_mode = SCAN_SKIP;
      skip_left = 2'd3;
    end
  endfunction

  function automatic void scan_byte(input logic [7:0] b, input logic fin);
    logic [EXT_W-1:0] ext;
    case (scan_mode)
      SCAN_TEXT: begin
        take_text_byte(b);
      end
      SCAN_ESC: begin
        if (b == CSI_OPEN) begin
          scan_mode = SCAN_CSI;
        end else begin
          add_cols(1);
          scan_mode = SCAN_TEXT;
          take_text_byte(b);
        end
      end
      SCAN_CSI: begin
        if (b >= CSI_FINAL_LO && b <= CSI_FINAL_HI) scan_mode = SCAN_TEXT;
      end
      default: begin
        if (skip_left <= 2'd1) begin
          skip_left = 2'd0;
          scan_mode = SCAN_TEXT;
        end else begin
          skip_left = skip_left - 2'd1;
        end
      end
    endcase
    if (fin) begin
      // An ESC still pending at the end of the string counts as one column.
      if (scan_mode == SCAN_ESC) add_cols(1);
      ext = EXT_W'(col_acc);
      width_q.push_back((ext > EXT_W'({COL_W{1'b1}})) ? {COL_W{1'b1}} : COL_W'(ext));
      scan_mode = SCAN_TEXT;
      skip_left = 2'd0;
      col_acc = '0;
    end
  endfunction

  // Driver: offers the next pending item unless idling, holds while stalled.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        scan_byte(text_byte, is_final_byte);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_item = byte_q.pop_front();
          in_valid <= 1'b1;
          text_byte <= next_item.text_byte;
          is_final_byte <= next_item.is_final_byte;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted on its own.
  always @(posedge clk) begin
    if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst || hold_left != 0) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Monitor: every taken result is matched against the oldest expected width.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (width_q.size() == 0) begin
        report_mismatch("width with no string pending", column_width, '0);
      end else begin
        want_width = width_q.pop_front();
        if (column_width !== want_width) begin
          report_mismatch("column_width", column_width, want_width);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Queues the bytes in str as one string, marking the last one final.
  task automatic send_string();
    item_t it;
    for (int i = 0; i < str.size(); i++) begin
      it.text_byte = str[i];
      it.is_final_byte = (i == str.size() - 1);
      byte_q.push_back(it);
      n_pushed++;
    end
    str.delete();
  endtask

  // A string of a few random pieces; most are well formed, some are noise,
  // and now and then the string is cut off part way through a piece.
  task automatic build_random_string();
    int unsigned pieces;
    int unsigned kind;
    int unsigned n;
    if ($urandom_range(0, 9) == 0) pieces = $urandom_range(0, 20);
    else pieces = $urandom_range(1, 6);
    for (int p = 0; p < pieces; p++) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        str.push_back(8'($urandom_range(32, 126)));
      end else if (kind < 38) begin
        str.push_back(8'($urandom_range(0, 31)));
      end else if (kind < 55) begin
        str.push_back(ESC_BYTE);
        str.push_back(CSI_OPEN);
        n = $urandom_range(0, 4);
        for (int k = 0; k < n; k++) str.push_back(8'($urandom_range(8'h20, 8'h3F)));
        if ($urandom_range(0, 9) == 0) str.push_back(8'($urandom_range(0, 255)));
        str.push_back(8'($urandom_range(CSI_FINAL_LO, CSI_FINAL_HI)));
      end else if (kind < 62) begin
        str.push_back(ESC_BYTE);
        str.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 82) begin
        n = $urandom_range(2, 4);
        case (n)
          2: str.push_back(LEAD2_CODE | 8'($urandom_range(0, 31)));
          3: str.push_back(LEAD3_CODE | 8'($urandom_range(0, 15)));
          default: str.push_back(LEAD4_CODE | 8'($urandom_range(0, 7)));
        endcase
        for (int k = 1; k < n; k++) begin
          if ($urandom_range(0, 9) == 0) str.push_back(8'($urandom_range(0, 255)));
          else str.push_back(8'h80 | 8'($urandom_range(0, 63)));
        end
      end else if (kind < 92) begin
        str.push_back(8'($urandom_range(0, 255)));
      end else begin
        str.push_back(8'($urandom_range(8'hF8, 8'hFF)));
      end
    end
    if (str.size() == 0) str.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 99) < 15) begin
      n = $urandom_range(1, str.size());
      while (str.size() > n) void'(str.pop_back());
    end
    send_string();
  endtask

  task automatic wait_drained();
    while (n_accepted != n_pushed || width_q.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input bit pressure);
    int unsigned start;
    send_idle_pct = idle;
    stall_pct = stall;
    start = n_pushed;
    while (n_pushed - start < PHASE_BYTES) build_random_string();
    if (pressure) begin
      @(posedge clk);
      hold_go <= 1'b1;
      @(posedge clk);
      hold_go <= 1'b0;
    end
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Single bytes at the edges of each class.
    str = '{8'h41};                          send_string();
    str = '{8'h00};                          send_string();
    str = '{8'h7F};                          send_string();
    str = '{8'hFF};                          send_string();
    str = '{8'h80};                          send_string();
    str = '{8'hF8};                          send_string();
    // Pending ESC at the end, and two ESCs in a row.
    str = '{ESC_BYTE};                       send_string();
    str = '{ESC_BYTE, ESC_BYTE};             send_string();
    // A complete CSI sequence followed by text.
    str = '{ESC_BYTE, CSI_OPEN, 8'h33, 8'h31, 8'h6D, 8'h78};
    send_string();
    // Two, three and four byte characters.
    str = '{8'hC3, 8'hA9, 8'hE4, 8'hB8, 8'hAD, 8'hF0, 8'h9F, 8'h98, 8'h80};
    send_string();
    // Cut-off character and cut-off CSI.
    str = '{8'hE4};                          send_string();
    str = '{ESC_BYTE, CSI_OPEN, 8'h33};      send_string();
    // A skipped byte is ignored even when it looks like ESC.
    str = '{8'hC3, ESC_BYTE, 8'h61};         send_string();
    wait_drained();

    run_phase(0, 0, 1'b0);
    run_phase(80, 0, 1'b0);
    run_phase(0, 80, 1'b0);
    run_phase(34, 34, 1'b0);
    run_phase(0, 0, 1'b1);

    repeat (10) @(posedge clk);
    while (width_q.size() != 0) begin
      report_mismatch("width never produced", '0, width_q.pop_front());
    end
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
